### rtl/core/cfbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfbe_pkg
// Shared types and constants for the CAN frame bit encoder.
// ----------------------------------------------------------------------------
package cfbe_pkg;

	// input transaction layout
	localparam int IN_TDATA_W  = 104;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 16;

	// frame layout
	localparam int FRAME_W      = 103;   // longest header plus eight data bytes
	localparam int STD_HDR_BITS = 19;    // SOF, id 11, RTR, IDE, r0, DLC 4
	localparam int EXT_HDR_BITS = 39;    // SOF, id 11, SRR, IDE, id 18, RTR, r1, r0, DLC 4
	localparam int LEN_W        = 7;

	// CRC-15
	localparam int             CRC_W    = 15;
	localparam logic [CRC_W-1:0] CRC_POLY = 15'h4599;

	// bit stuffing
	localparam logic [2:0] STUFF_RUN = 3'd5;

	// control of the shared CRC unit
	typedef struct packed {
		logic clr;     // clear to zero for a new frame
		logic step;    // fold one raw bit into the remainder
		logic shift;   // shift the remainder out, MSB first
	} crc_ctl_t;

endpackage

`default_nettype wire

### rtl/core/cfbe_crc15.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfbe_crc15
// CRC-15 register: divides raw bits one per step, then shifts the remainder
// out for transmission.
// ----------------------------------------------------------------------------
module cfbe_crc15 (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire cfbe_pkg::crc_ctl_t ctl,
	input  wire                    raw_bit,
	output logic                   crc_msb
);
	import cfbe_pkg::*;

	logic [CRC_W-1:0] crc_q;
	logic             fb;

	assign fb      = raw_bit ^ crc_q[CRC_W-1];
	assign crc_msb = crc_q[CRC_W-1];

	// remainder update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (ctl.clr) begin
			crc_q <= '0;
		end else if (ctl.step) begin
			crc_q <= {crc_q[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
		end else if (ctl.shift) begin
			crc_q <= {crc_q[CRC_W-2:0], 1'b0};
		end
	end

endmodule

`default_nettype wire

### rtl/core/can_frame_bit_encoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_frame_bit_encoder_core
// Encodes one classic CAN frame into stuffed line bits, SOF through the CRC
// delimiter, grouped GROUP_BITS bits per output transaction.
// ----------------------------------------------------------------------------
// Throughput: one line bit per cycle from the serializer while the output is not
//   stalled, stuff bits included; the shared CRC register steps once per raw
//   data bit and shifts once per CRC bit.
// Input ready only between frames; output back-pressure stalls the serializer.
// Reset (arst_n low) clears the sequencer, stuffing state and output valid.
// ----------------------------------------------------------------------------
module can_frame_bit_encoder_core #(
	parameter int GROUP_BITS = 8
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// identifier[28:0], dlc[32:29], payload[96:33], zero[103:97]
	input  wire [cfbe_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// extended[0], remote[1]
	input  wire [cfbe_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	// line_bits[7:0], bit_count[11:8], zero[15:12]
	output logic [cfbe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                             m_axis_tlast,
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready
);
	import cfbe_pkg::*;

	localparam int GW = $clog2(GROUP_BITS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DATA,
		ST_CRC,
		ST_DELIM
	} state_t;

	state_t                 state_q;
	logic [FRAME_W-1:0]     sr_q;
	logic [LEN_W-1:0]       cnt_q;
	logic                   prev_q;
	logic [2:0]             run_q;
	logic                   stuff_q;
	logic [GROUP_BITS-1:0]  grp_q;
	logic [GW-1:0]          gcnt_q;
	logic [7:0]             line_q;
	logic [3:0]             bcnt_q;
	logic                   last_q;
	logic                   mvalid_q;

	// input fields
	logic [28:0] in_id;
	logic [3:0]  in_dlc;
	logic [63:0] in_payload;
	logic        in_ext;
	logic        in_rtr;
	logic        accept;
	logic [3:0]  nbytes;
	logic [LEN_W-1:0] raw_len;
	logic [FRAME_W-1:0] frame_init;

	assign in_id      = s_axis_tdata[28:0];
	assign in_dlc     = s_axis_tdata[32:29];
	assign in_payload = s_axis_tdata[96:33];
	assign in_ext     = s_axis_tuser[0];
	assign in_rtr     = s_axis_tuser[1];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// header and data laid out MSB first; raw_len marks where data stops
	always_comb begin
		if (in_rtr) begin
			nbytes = 4'd0;
		end else if (in_dlc[3]) begin
			nbytes = 4'd8;
		end else begin
			nbytes = {1'b0, in_dlc[2:0]};
		end
		if (in_ext) begin
			frame_init = {1'b0, in_id[28:18], 2'b11, in_id[17:0], in_rtr, 2'b00,
				in_dlc, in_payload};
			raw_len    = LEN_W'(EXT_HDR_BITS) + {nbytes, 3'b000};
		end else begin
			frame_init = {1'b0, in_id[10:0], in_rtr, 2'b00, in_dlc, in_payload,
				20'h0};
			raw_len    = LEN_W'(STD_HDR_BITS) + {nbytes, 3'b000};
		end
	end

	// bit selection and emit gating
	logic     crc_msb;
	logic     line_bit;
	logic     raw_emit;
	logic     closes;
	logic     slot_free;
	logic     emit;
	logic     end_bit;
	crc_ctl_t crc_ctl;

	assign slot_free = !mvalid_q || m_axis_tready;
	assign end_bit   = (state_q == ST_DELIM) && !stuff_q;
	assign closes    = (gcnt_q == GW'(GROUP_BITS - 1)) || end_bit;
	assign emit      = (state_q != ST_IDLE) && (!closes || slot_free);
	assign raw_emit  = emit && !stuff_q &&
		((state_q == ST_DATA) || (state_q == ST_CRC));

	always_comb begin
		if (stuff_q) begin
			line_bit = !prev_q;
		end else begin
			case (state_q)
				ST_DATA: line_bit = sr_q[FRAME_W-1];
				ST_CRC:  line_bit = crc_msb;
				default: line_bit = 1'b1;
			endcase
		end
	end

	assign crc_ctl.clr   = accept;
	assign crc_ctl.step  = raw_emit && (state_q == ST_DATA);
	assign crc_ctl.shift = raw_emit && (state_q == ST_CRC);

	cfbe_crc15 u_crc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (crc_ctl),
		.raw_bit (sr_q[FRAME_W-1]),
		.crc_msb (crc_msb)
	);

	// next group contents: bit goes at its left-aligned place
	logic [GROUP_BITS-1:0] grp_n;
	logic [4:0]            cnt_n;

	always_comb begin
		for (int k = 0; k < GROUP_BITS; k++) begin
			if (gcnt_q == GW'(GROUP_BITS - 1 - k)) begin
				grp_n[k] = line_bit;
			end else if (gcnt_q == '0) begin
				grp_n[k] = 1'b0;
			end else begin
				grp_n[k] = grp_q[k];
			end
		end
		cnt_n = 5'(gcnt_q) + 5'd1;
	end

	// sequencer, stuffing and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			prev_q   <= 1'b1;
			run_q    <= '0;
			stuff_q  <= 1'b0;
			gcnt_q   <= '0;
			mvalid_q <= 1'b0;
		end else begin
			// a group closing this cycle refills the output slot instead
			if (mvalid_q && m_axis_tready && !(emit && closes)) begin
				mvalid_q <= 1'b0;
			end
			if (accept) begin
				state_q <= ST_DATA;
				sr_q    <= frame_init;
				cnt_q   <= raw_len;
				prev_q  <= 1'b1;
				run_q   <= '0;
				stuff_q <= 1'b0;
				gcnt_q  <= '0;
			end else if (emit) begin
				grp_q <= grp_n;
				if (closes) begin
					gcnt_q   <= '0;
					line_q   <= 8'(({grp_n, 8'h00}) >> GROUP_BITS);
					bcnt_q   <= cnt_n[3:0];
					last_q   <= end_bit;
					mvalid_q <= 1'b1;
				end else begin
					gcnt_q <= gcnt_q + GW'(1);
				end
				if (stuff_q) begin
					// stuff bit opens the next run
					prev_q  <= line_bit;
					run_q   <= 3'd1;
					stuff_q <= 1'b0;
				end else if (raw_emit) begin
					prev_q <= line_bit;
					if (line_bit == prev_q) begin
						run_q <= run_q + 3'd1;
						if (run_q + 3'd1 == STUFF_RUN) begin
							stuff_q <= 1'b1;
						end
					end else begin
						run_q <= 3'd1;
					end
				end
				case (state_q)
					ST_DATA: begin
						if (!stuff_q) begin
							sr_q <= {sr_q[FRAME_W-2:0], 1'b0};
							if (cnt_q == LEN_W'(1)) begin
								state_q <= ST_CRC;
								cnt_q   <= LEN_W'(CRC_W);
							end else begin
								cnt_q <= cnt_q - LEN_W'(1);
							end
						end
					end
					ST_CRC: begin
						if (!stuff_q) begin
							cnt_q <= cnt_q - LEN_W'(1);
							if (cnt_q == LEN_W'(1)) begin
								state_q <= ST_DELIM;
							end
						end
					end
					ST_DELIM: begin
						if (!stuff_q) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	assign m_axis_tvalid = mvalid_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {4'h0, bcnt_q, line_q};

	// checks
	a_idle_no_stuff : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !stuff_q)
		else $error("stuff bit pending between frames");

	a_idle_group_empty : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (gcnt_q == '0))
		else $error("partial group left after frame end");

	a_run_bounded : assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= STUFF_RUN)
		else $error("run length exceeded stuffing limit");

	a_stuff_after_run : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stuff_q) |-> (run_q == STUFF_RUN))
		else $error("stuff bit raised without a full run");

endmodule

`default_nettype wire
